// ----- sv/nfc_pkg.sv -----
// nfc_pkg: shared types, widths and lookup tables of the NFC normalizer.
// No dependencies; used by every module of the block.
package nfc_pkg;

  localparam int CpW          = 21;
  localparam int ClsW         = 8;
  localparam int MaxMarksDef  = 8;

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [ClsW-1:0] cls;
    logic            eot;
  } nfc_item_t;

  // Combining class; anything not listed is a starter.
  function automatic logic [ClsW-1:0] nfc_class(input logic [CpW-1:0] cp);
    logic [ClsW-1:0] c;
    c = '0;
    case (cp)
      21'h00300, 21'h00301, 21'h00302, 21'h00303, 21'h00304, 21'h00306,
      21'h00307, 21'h00308, 21'h0030A, 21'h0030B, 21'h0030C,
      21'h10F82, 21'h10F84:                         c = 8'd230;
      21'h00327, 21'h00328:                         c = 8'd202;
      21'h00323, 21'h00324, 21'h00325, 21'h00331, 21'h00332,
      21'h10F83, 21'h10F85:                         c = 8'd220;
      default:                                      c = '0;
    endcase
    return c;
  endfunction

  // Canonical composition of starter + mark; zero when no pair exists.
  function automatic logic [CpW-1:0] nfc_pair(input logic [CpW-1:0] st,
                                               input logic [CpW-1:0] mk);
    logic [CpW-1:0] r;
    r = '0;
    case ({st, mk})
      {21'h00041, 21'h00308}: r = 21'h000C4;
      {21'h00061, 21'h00308}: r = 21'h000E4;
      {21'h0004F, 21'h00308}: r = 21'h000D6;
      {21'h0006F, 21'h00308}: r = 21'h000F6;
      {21'h00055, 21'h00308}: r = 21'h000DC;
      {21'h00075, 21'h00308}: r = 21'h000FC;
      {21'h00041, 21'h00301}: r = 21'h000C1;
      {21'h00061, 21'h00301}: r = 21'h000E1;
      {21'h00045, 21'h00301}: r = 21'h000C9;
      {21'h00065, 21'h00301}: r = 21'h000E9;
      {21'h00041, 21'h00300}: r = 21'h000C0;
      {21'h00061, 21'h00300}: r = 21'h000E0;
      {21'h0004E, 21'h00303}: r = 21'h000D1;
      {21'h0006E, 21'h00303}: r = 21'h000F1;
      {21'h00043, 21'h00327}: r = 21'h000C7;
      {21'h00063, 21'h00327}: r = 21'h000E7;
      default:                r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/nfc_front.sv -----
// nfc_front: accepts code points, looks up their combining class and holds
// them in a two-word queue for the back end. Depends on nfc_pkg.
module nfc_front import nfc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [CpW-1:0]  code_point_i,
  input  logic            end_of_text_i,
  output logic            item_valid_o,
  output nfc_item_t       item_o,
  input  logic            item_pop_i
);

  nfc_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign full         = (cnt_q == 2'd2);
  assign wr_en        = push && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign rd_en        = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q].cp  <= code_point_i;
      mem_q[wr_q].cls <= nfc_class(code_point_i);
      mem_q[wr_q].eot <= end_of_text_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ----- sv/nfc_back.sv -----
// nfc_back: cluster buffer with sorted insertion, compose walk and emit walk,
// ending in a one-word output register. Depends on nfc_pkg.
module nfc_back import nfc_pkg::*; #(
  parameter int MaxMarks = MaxMarksDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  nfc_item_t       item_i,
  output logic            item_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [CpW-1:0]  out_code_point_o,
  output logic            last_of_run_o,
  output logic            text_done_o,
  output logic            run_overflow_o
);

  localparam int Depth = MaxMarks + 1;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_EOT  = 3'd2;
  localparam logic [2:0] S_COMP = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [CpW-1:0]  pt_q [Depth];
  logic [CpW-1:0]  pt_d [Depth];
  logic [ClsW-1:0] cl_q [Depth];
  logic [ClsW-1:0] cl_d [Depth];
  logic [CW-1:0]   cnt_q, cnt_d, idx_q, idx_d, first, marks;
  logic            has_st_q, has_st_d;
  logic [2:0]      state_q, state_d;
  nfc_item_t       cur_q, cur_d;
  logic [Depth-1:0] kept_q, kept_d, gt, gt_sh, above;
  logic [CpW-1:0]  comp_q, comp_d, pr, rd_pt;
  logic [ClsW-1:0] lcls_q, lcls_d, rd_cl;
  logic            emit_st_q, emit_st_d, ovf_q, ovf_d, last_q, last_d;
  logic            done_q, done_d, pre_q, pre_d;
  logic            out_valid_q, out_ready, out_we, out_last;
  logic [CpW-1:0]  out_cp;

  assign first     = has_st_q ? CW'(1) : CW'(0);
  assign marks     = cnt_q - first;
  assign out_ready = !out_valid_q || pop;
  assign rd_pt     = pt_q[idx_q[AW-1:0]];
  assign rd_cl     = cl_q[idx_q[AW-1:0]];
  assign pr        = nfc_pair(comp_q, rd_pt);
  assign above     = (kept_q >> idx_q) >> 1;

  // marks that sort after the incoming one form a suffix of the cluster
  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      gt[j] = (CW'(j) >= first) && (CW'(j) < cnt_q) && (cl_q[j] > cur_q.cls);
    end
    gt_sh = {gt[Depth-2:0], 1'b0};
  end

  always_comb begin
    pt_d = pt_q; cl_d = cl_q;
    cnt_d = cnt_q; has_st_d = has_st_q; state_d = state_q; cur_d = cur_q;
    idx_d = idx_q; kept_d = kept_q; comp_d = comp_q; lcls_d = lcls_q;
    emit_st_d = emit_st_q; ovf_d = ovf_q; last_d = last_q; done_d = done_q;
    pre_d = pre_q;
    item_pop_o = 1'b0; out_we = 1'b0; out_cp = comp_q; out_last = 1'b0;
    case (state_q)
      S_IDLE: begin
        item_pop_o = item_valid_i;
        if (item_valid_i) begin
          cur_d = item_i;
          if ((item_i.cls == '0) ? (cnt_q != '0) : (marks >= CW'(MaxMarks))) begin
            idx_d = first; comp_d = pt_q[0]; lcls_d = '0; kept_d = '0;
            ovf_d = (item_i.cls != '0); last_d = !item_i.eot;
            done_d = 1'b0; pre_d = 1'b1; state_d = S_COMP;
          end else begin
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        if (cur_q.cls == '0) begin
          pt_d[0] = cur_q.cp; cl_d[0] = '0; cnt_d = CW'(1); has_st_d = 1'b1;
        end else begin
          for (int j = 0; j < Depth; j++) begin
            if (gt_sh[j]) begin
              pt_d[j] = pt_q[(j + Depth - 1) % Depth];
              cl_d[j] = cl_q[(j + Depth - 1) % Depth];
            end else if (gt[j] || CW'(j) == cnt_q) begin
              pt_d[j] = cur_q.cp; cl_d[j] = cur_q.cls;
            end
          end
          cnt_d = cnt_q + CW'(1);
        end
        state_d = cur_q.eot ? S_EOT : S_IDLE;
      end
      S_EOT: begin
        idx_d = first; comp_d = pt_q[0]; lcls_d = '0; kept_d = '0;
        ovf_d = 1'b0; last_d = 1'b1; done_d = 1'b1; pre_d = 1'b0;
        state_d = S_COMP;
      end
      S_COMP: begin
        if (idx_q < cnt_q) begin
          if (has_st_q && rd_cl > lcls_q && pr != '0) begin
            comp_d = pr;
          end else begin
            kept_d[idx_q[AW-1:0]] = 1'b1;
            lcls_d = rd_cl;
          end
          idx_d = idx_q + CW'(1);
        end else begin
          emit_st_d = has_st_q; idx_d = first; state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_st_q) begin
          out_we = out_ready; out_cp = comp_q;
          out_last = last_q && (kept_q == '0);
          if (out_ready) emit_st_d = 1'b0;
        end else if (idx_q < cnt_q) begin
          if (kept_q[idx_q[AW-1:0]]) begin
            out_we = out_ready; out_cp = rd_pt;
            out_last = last_q && (above == '0);
            if (out_ready) idx_d = idx_q + CW'(1);
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end else begin
          cnt_d = '0; has_st_d = 1'b0;
          state_d = pre_q ? S_INS : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d; cl_q <= cl_d; cur_q <= cur_d; idx_q <= idx_d;
    kept_q <= kept_d; comp_q <= comp_d; lcls_q <= lcls_d;
    ovf_q <= ovf_d; last_q <= last_d; done_q <= done_d; pre_q <= pre_d;
    if (out_we) begin
      out_code_point_o <= out_cp;
      last_of_run_o    <= out_last;
      text_done_o      <= out_last && done_q;
      run_overflow_o   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; has_st_q <= 1'b0;
      emit_st_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; has_st_q <= has_st_d;
      emit_st_q <= emit_st_d;
      if (out_we)   out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  assign empty = !out_valid_q;

endmodule

// ----- sv/unicode_nfc_normalizer_core.sv -----
// unicode_nfc_normalizer_core: NFC reordering and composition of a code point
// stream. Depends on nfc_pkg, nfc_front and nfc_back.
//
//  channel | handshake          | words
//  --------+--------------------+---------------------------------------------
//  input   | push / full        | code_point_i, end_of_text_i
//  result  | empty / pop        | out_code_point_o, last_of_run_o,
//          |                    | text_done_o, run_overflow_o
//
// Without a flush each word passes the fetch and insert states. A flush
// runs the compose walk over the marks (after an end-of-text state when
// end of text starts it) and the emit walk, one buffered entry per cycle
// unless the output stalls, through the single cluster read port.
// Reset is asynchronous, active low; the cluster entries are not cleared.
// A stalled result holds in the output register; the front queue keeps
// taking up to two words meanwhile.
module unicode_nfc_normalizer_core import nfc_pkg::*; #(
  parameter int MaxMarks = MaxMarksDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [CpW-1:0]  code_point_i,
  input  logic            end_of_text_i,
  output logic            empty,
  input  logic            pop,
  output logic [CpW-1:0]  out_code_point_o,
  output logic            last_of_run_o,
  output logic            text_done_o,
  output logic            run_overflow_o
);

  nfc_item_t item;
  logic      item_valid, item_pop;

  // front: class lookup and decoupling queue
  nfc_front u_front (
    .clk_i, .rst_ni, .push, .full, .code_point_i, .end_of_text_i,
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // back: sorted cluster buffer, compose and emit sequencer
  nfc_back #(.MaxMarks(MaxMarks)) u_back (
    .clk_i, .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .empty, .pop, .out_code_point_o, .last_of_run_o, .text_done_o,
    .run_overflow_o
  );

endmodule

// ----- sv/nfc_checker.sv -----
// nfc_checker: port-level assertions for unicode_nfc_normalizer_core, and
// the bind that attaches them. Depends on nfc_pkg.
module nfc_checker import nfc_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            full,
  input logic            empty,
  input logic            pop,
  input logic [CpW-1:0]  out_code_point_o,
  input logic            last_of_run_o,
  input logic            text_done_o,
  input logic            run_overflow_o
);

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("queues not empty in reset");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && text_done_o) |-> last_of_run_o)
    else $error("text_done without last_of_run");

  a_ovf_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && run_overflow_o) |-> !text_done_o)
    else $error("early flush marked as end of text");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty && $stable(out_code_point_o))
    else $error("stalled result changed");

endmodule

bind unicode_nfc_normalizer_core nfc_checker u_nfc_checker (.*);

// ----- verif/unicode_nfc_normalizer_core_tb.sv -----
// Testbench for unicode_nfc_normalizer_core: random and directed code point
// streams checked word by word against a behavioral NFC cluster predictor.
// Depends on nfc_pkg (widths) and the core RTL.
module unicode_nfc_normalizer_core_tb;
  import nfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MarkLimit = MaxMarksDef;
  localparam int Depth     = MarkLimit + 1;
  localparam int CycleCap  = 400000;

  // one predicted result word
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           last;
    logic           done;
    logic           ovf;
  } nfc_word_t;

  // one stimulus word
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           eot;
  } src_word_t;

  logic           clk_i, rst_ni;
  logic           push, full, empty, pop;
  logic [CpW-1:0] code_point_i, out_code_point_o;
  logic           end_of_text_i, last_of_run_o, text_done_o, run_overflow_o;

  unicode_nfc_normalizer_core uut (
    .clk_i, .rst_ni, .push, .full, .code_point_i, .end_of_text_i,
    .empty, .pop, .out_code_point_o, .last_of_run_o, .text_done_o,
    .run_overflow_o
  );

  src_word_t src_q[$];
  nfc_word_t expected_q[$];
  int        err_cnt;
  int        send_idle_pct, recv_idle_pct;
  bit        hold_send;   // sender pauses while set
  bit        stim_done;
  int        cycle_cnt;

  // Predictor state: the buffered cluster.
  logic [CpW-1:0] clu_cp[Depth];
  logic [7:0]     clu_cls[Depth];
  int             clu_cnt;
  bit             clu_starter;

  // Combining class table, written independently of the package.
  function automatic logic [7:0] comb_class(logic [CpW-1:0] cp);
    case (cp)
      21'h00300, 21'h00301, 21'h00302, 21'h00303, 21'h00304, 21'h00306,
      21'h00307, 21'h00308, 21'h0030A, 21'h0030B, 21'h0030C,
      21'h10F82, 21'h10F84: return 8'd230;
      21'h00327, 21'h00328: return 8'd202;
      21'h00323, 21'h00324, 21'h00325, 21'h00331, 21'h00332,
      21'h10F83, 21'h10F85: return 8'd220;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [CpW-1:0] compose(logic [CpW-1:0] st, logic [CpW-1:0] mk);
    logic [CpW-1:0] base[16] = '{21'h41, 21'h61, 21'h4F, 21'h6F, 21'h55, 21'h75,
      21'h41, 21'h61, 21'h45, 21'h65, 21'h41, 21'h61, 21'h4E, 21'h6E, 21'h43, 21'h63};
    logic [CpW-1:0] mark[16] = '{21'h308, 21'h308, 21'h308, 21'h308, 21'h308,
      21'h308, 21'h301, 21'h301, 21'h301, 21'h301, 21'h300, 21'h300, 21'h303,
      21'h303, 21'h327, 21'h327};
    logic [CpW-1:0] res[16] = '{21'hC4, 21'hE4, 21'hD6, 21'hF6, 21'hDC, 21'hFC,
      21'hC1, 21'hE1, 21'hC9, 21'hE9, 21'hC0, 21'hE0, 21'hD1, 21'hF1, 21'hC7, 21'hE7};
    for (int i = 0; i < 16; i++)
      if (base[i] == st && mark[i] == mk) return res[i];
    return '0;
  endfunction

  // Sort, compose and emit the cluster into the list of predicted words.
  function automatic void flush_cluster(ref nfc_word_t outs[$], input bit ovf);
    int             first, j;
    logic [CpW-1:0] st, p;
    logic [7:0]     c, last_cls;
    logic [CpW-1:0] r;
    logic [CpW-1:0] kept[$];
    first = clu_starter ? 1 : 0;
    st = clu_cp[0];
    last_cls = 0;
    for (int i = first + 1; i < clu_cnt; i++) begin
      p = clu_cp[i];
      c = clu_cls[i];
      j = i;
      while (j > first && clu_cls[j-1] > c) begin
        clu_cp[j] = clu_cp[j-1];
        clu_cls[j] = clu_cls[j-1];
        j--;
      end
      clu_cp[j] = p;
      clu_cls[j] = c;
    end
    for (int i = first; i < clu_cnt; i++) begin
      r = '0;
      if (clu_starter && clu_cls[i] > 0 && clu_cls[i] > last_cls)
        r = compose(st, clu_cp[i]);
      if (r != 0) begin
        st = r;
      end else begin
        kept.push_back(clu_cp[i]);
        last_cls = clu_cls[i];
      end
    end
    if (clu_starter && clu_cnt > 0) outs.push_back('{st, 1'b0, 1'b0, ovf});
    foreach (kept[k]) outs.push_back('{kept[k], 1'b0, 1'b0, ovf});
    clu_cnt = 0;
    clu_starter = 0;
  endfunction

  // Advance the predictor by one accepted word, queue the results.
  function automatic void predict_nfc(src_word_t w);
    nfc_word_t outs[$];
    logic [7:0] cls;
    cls = comb_class(w.cp);
    if (cls == 0) begin
      if (clu_cnt > 0) flush_cluster(outs, 1'b0);
      clu_cp[0] = w.cp;
      clu_cls[0] = 0;
      clu_cnt = 1;
      clu_starter = 1;
    end else begin
      if (clu_cnt - (clu_starter ? 1 : 0) >= MarkLimit) flush_cluster(outs, 1'b1);
      if (clu_cnt < Depth) begin
        clu_cp[clu_cnt] = w.cp;
        clu_cls[clu_cnt] = cls;
        clu_cnt++;
      end
    end
    if (w.eot) flush_cluster(outs, 1'b0);
    if (outs.size() > 0) begin
      outs[outs.size()-1].last = 1'b1;
      outs[outs.size()-1].done = w.eot;
    end
    foreach (outs[k]) expected_q.push_back(outs[k]);
  endfunction

  // Stimulus pools: letters that compose, plain starters and every mark.
  function automatic logic [CpW-1:0] pick_starter();
    logic [CpW-1:0] ltr[10] = '{21'h41, 21'h61, 21'h4F, 21'h6F, 21'h55, 21'h45,
                                21'h4E, 21'h6E, 21'h43, 21'h63};
    case ($urandom_range(0, 9))
      0: return CpW'($urandom_range(0, 21'h1FFFFF));   // anything, out of range too
      1: return CpW'($urandom_range(21'h110000, 21'h1FFFFF));
      2: return 21'h000000;
      default: return ltr[$urandom_range(0, 9)];
    endcase
  endfunction

  function automatic logic [CpW-1:0] pick_mark();
    logic [CpW-1:0] mk[22] = '{21'h300, 21'h301, 21'h302, 21'h303, 21'h304, 21'h306,
      21'h307, 21'h308, 21'h30A, 21'h30B, 21'h30C, 21'h327, 21'h328, 21'h323,
      21'h324, 21'h325, 21'h331, 21'h332, 21'h10F82, 21'h10F83, 21'h10F84, 21'h10F85};
    return mk[$urandom_range(0, 21)];
  endfunction

  // Clock.
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: one word from the pending queue per accepted push.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      code_point_i <= '0;
      end_of_text_i <= 1'b0;
    end else begin
      if (push && !full) predict_nfc('{code_point_i, end_of_text_i});
      if (!push || !full) begin
        if (src_q.size() > 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          src_word_t w;
          w = src_q.pop_front();
          push <= 1'b1;
          code_point_i <= w.cp;
          end_of_text_i <= w.eot;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word cp=%h", $time, out_code_point_o);
          err_cnt++;
        end else begin
          nfc_word_t e;
          e = expected_q.pop_front();
          if (e.cp !== out_code_point_o) begin
            $display("%0t: cp exp %h got %h", $time, e.cp, out_code_point_o);
            err_cnt++;
          end
          if (e.last !== last_of_run_o) begin
            $display("%0t: last exp %b got %b", $time, e.last, last_of_run_o);
            err_cnt++;
          end
          if (e.done !== text_done_o) begin
            $display("%0t: done exp %b got %b", $time, e.done, text_done_o);
            err_cnt++;
          end
          if (e.ovf !== run_overflow_o) begin
            $display("%0t: ovf exp %b got %b", $time, e.ovf, run_overflow_o);
            err_cnt++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleCap) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Queue one cluster: optional starter, n marks, optional end of text.
  task automatic add_cluster(bit with_st, int n, bit eot);
    if (with_st) src_q.push_back('{pick_starter(), 1'b0});
    for (int i = 0; i < n; i++) src_q.push_back('{pick_mark(), 1'b0});
    if (eot && src_q.size() > 0) src_q[src_q.size()-1].eot = 1'b1;
  endtask

  task automatic wait_drained();
    while (src_q.size() > 0 || push || expected_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int rnd_cnt;
    err_cnt = 0;
    cycle_cnt = 0;
    hold_send = 0;
    send_idle_pct = 16;
    recv_idle_pct = 58;
    clu_cnt = 0;
    clu_starter = 0;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: marks with no starter, composition, blocked composition,
    // stable reordering, full mark run, extremes of the code point field.
    src_q.push_back('{21'h000301, 1'b0});
    src_q.push_back('{21'h000323, 1'b1});         // marks only, end of text
    src_q.push_back('{21'h000041, 1'b0});
    src_q.push_back('{21'h000308, 1'b0});         // A + diaeresis
    src_q.push_back('{21'h000063, 1'b0});
    src_q.push_back('{21'h000323, 1'b0});
    src_q.push_back('{21'h000327, 1'b0});         // c + dot below + cedilla
    src_q.push_back('{21'h00006E, 1'b0});
    src_q.push_back('{21'h000301, 1'b0});
    src_q.push_back('{21'h000303, 1'b1});         // second 230 mark blocked
    src_q.push_back('{21'h1FFFFF, 1'b0});         // out of range starter
    src_q.push_back('{21'h10FFFF, 1'b0});
    src_q.push_back('{21'h000000, 1'b1});
    src_q.push_back('{21'h000041, 1'b0});
    for (int i = 0; i < MarkLimit + 1; i++)       // full mark run
      src_q.push_back('{(i % 2) ? 21'h10F83 : 21'h10F82, 1'b0});
    src_q.push_back('{21'h000045, 1'b1});
    wait_drained();

    // Random phases with the three idling profiles.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 16 : 0;
      rnd_cnt = 0;
      while (rnd_cnt < 92) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(MarkLimit, MarkLimit + 3)
                                         : $urandom_range(0, 3);
        add_cluster($urandom_range(0, 9) != 0, n, $urandom_range(0, 5) == 0);
        rnd_cnt += n + 1;
      end
      if (ph == 0) begin
        // sender holds off until everything has drained
        hold_send = 1;
        while (push || expected_q.size() > 0) @(posedge clk_i);
        hold_send = 0;
      end
      add_cluster(1, 0, 1);                       // close the text
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
sv/nfc_pkg.sv
sv/nfc_front.sv
sv/nfc_back.sv
sv/unicode_nfc_normalizer_core.sv
sv/nfc_checker.sv
verif/unicode_nfc_normalizer_core_tb.sv
